FILE: rtl/core/one_wire_master_slot_timer_defines.svh
// Assertion macros shared by the RTL of the one-wire slot timer.
// Both macros sample on clk and are disabled while rst is high.
`ifndef ONE_WIRE_MASTER_SLOT_TIMER_DEFINES_SVH
`define ONE_WIRE_MASTER_SLOT_TIMER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge.
`define OWM_ASSERT_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("owm assertion failed: now");

// Check that a consequence holds in the cycle after its antecedent.
`define OWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("owm assertion failed: next");

`else

`define OWM_ASSERT_NOW(lbl, expr)
`define OWM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/owm_pkg.sv
`default_nettype none

package owm_pkg;

  // Input op codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_RESET = 3'd1;
  localparam logic [2:0] OP_SEND  = 3'd2;
  localparam logic [2:0] OP_RECV  = 3'd3;
  localparam logic [2:0] OP_KEY   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [2:0] CFG_RESET_RELEASE = 3'd1;
  localparam logic [2:0] CFG_SLOT_SHORT    = 3'd2;
  localparam logic [2:0] CFG_SLOT_LONG     = 3'd3;
  localparam logic [2:0] CFG_READ_TAIL     = 3'd4;
  localparam logic [2:0] CFG_KEY_PULSE     = 3'd5;
  localparam logic [2:0] CFG_KEY_GAP       = 3'd6;

  localparam int CFG_DATA_W = 14;
  localparam int TICK_W     = 14;

  // Register reset values
  localparam logic [9:0]  RESET_LOW_DEF     = 10'd480;
  localparam logic [7:0]  RESET_RELEASE_DEF = 8'd100;
  localparam logic [7:0]  SLOT_SHORT_DEF    = 8'd8;
  localparam logic [7:0]  SLOT_LONG_DEF     = 8'd72;
  localparam logic [7:0]  READ_TAIL_DEF     = 8'd32;
  localparam logic [7:0]  KEY_PULSE_DEF     = 8'd60;
  localparam logic [13:0] KEY_GAP_DEF       = 14'd10000;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL1  = 4'd2,
    PH_RST_WAIT  = 4'd3,
    PH_RST_REL2  = 4'd4,
    PH_SEND_LOW  = 4'd5,
    PH_SEND_REL  = 4'd6,
    PH_RECV_LOW  = 4'd7,
    PH_RECV_REL  = 4'd8,
    PH_RECV_TAIL = 4'd9,
    PH_KEY_LOW   = 4'd10,
    PH_KEY_GAP   = 4'd11
  } phase_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       line_in;
  } owm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } owm_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/one_wire_master_slot_timer.sv
// One-wire bus master sequencer, stepped by one-microsecond tick beats.
// Input channel (in_valid / in_stall / in_data): each beat is either a tick
// (op 0) carrying the sampled line level, or a start command (reset, send
// byte, receive byte, key-write byte) that takes effect only while idle.
// Output channel (out_valid / out_stall / out_data): exactly one result beat
// per input beat, in order: drive_low for the next tick, busy, a done pulse
// and the last received byte.
// Result beats are registered into the output buffer as inputs are taken.
// Throughput: one beat per cycle unless stalled; the phase/tick counter
// update is one increment and compare between state regs and result buffer.
// Stall: results collect in a two-entry output buffer; input keeps being taken
// while one result waits and in_stall rises only when both entries are full.
// Configuration: cfg_we writes cfg_data to cfg_index; the user must write
// only while idle; the block does not check it. Reset (rst, synchronous):
// sequencer idle, received byte zero, buffer empty, timing regs at defaults.
`default_nettype none
`include "one_wire_master_slot_timer_defines.svh"

module one_wire_master_slot_timer (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  owm_pkg::owm_in_t               in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output owm_pkg::owm_out_t              out_data,
  input  wire                            cfg_we,
  input  wire [2:0]                      cfg_index,
  input  wire [owm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import owm_pkg::*;

  // timing registers
  logic [9:0]  reset_low_len;
  logic [7:0]  reset_release_len;
  logic [7:0]  slot_short_len;
  logic [7:0]  slot_long_len;
  logic [7:0]  read_tail_len;
  logic [7:0]  key_pulse_len;
  logic [13:0] key_gap_len;

  // sequencer state
  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [TICK_W-1:0]   tick_inc;
  logic [TICK_W-1:0]   len_cur;
  logic [2:0]          bit_index, bit_index_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic [7:0]          received_byte, received_byte_next;
  logic                fin;
  owm_out_t            res;

  // output buffer
  owm_out_t   slot0, slot1;
  logic [1:0] count;
  logic       in_acc, out_pop;

  assign in_stall  = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot0;
  assign in_acc    = in_valid && !in_stall;
  assign out_pop   = out_valid && !out_stall;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_len     <= RESET_LOW_DEF;
      reset_release_len <= RESET_RELEASE_DEF;
      slot_short_len    <= SLOT_SHORT_DEF;
      slot_long_len     <= SLOT_LONG_DEF;
      read_tail_len     <= READ_TAIL_DEF;
      key_pulse_len     <= KEY_PULSE_DEF;
      key_gap_len       <= KEY_GAP_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESET_LOW:     reset_low_len     <= cfg_data[9:0];
        CFG_RESET_RELEASE: reset_release_len <= cfg_data[7:0];
        CFG_SLOT_SHORT:    slot_short_len    <= cfg_data[7:0];
        CFG_SLOT_LONG:     slot_long_len     <= cfg_data[7:0];
        CFG_READ_TAIL:     read_tail_len     <= cfg_data[7:0];
        CFG_KEY_PULSE:     key_pulse_len     <= cfg_data[7:0];
        CFG_KEY_GAP:       key_gap_len       <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // select the length of the current phase
  always_comb begin
    unique case (phase) inside
      PH_RST_LOW:                len_cur = TICK_W'(reset_low_len);
      PH_RST_REL1, PH_RST_REL2:  len_cur = TICK_W'(reset_release_len);
      PH_SEND_LOW:
        len_cur = TICK_W'(shift_byte[0] ? slot_short_len : slot_long_len);
      PH_SEND_REL:
        len_cur = TICK_W'(shift_byte[0] ? slot_long_len : slot_short_len);
      PH_RECV_LOW, PH_RECV_REL:  len_cur = TICK_W'(slot_short_len);
      PH_RECV_TAIL:              len_cur = TICK_W'(read_tail_len);
      PH_KEY_LOW:
        len_cur = shift_byte[0] ? TICK_W'(key_pulse_len) : TICK_W'(1);
      PH_KEY_GAP:                len_cur = key_gap_len;
      default:                   len_cur = TICK_W'(1);
    endcase
  end

  assign tick_inc = tick_count + TICK_W'(1);

  // next state and result for the beat at the input
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    received_byte_next = received_byte;
    fin                = 1'b0;

    if (in_data.op == OP_TICK) begin
      if (phase == PH_RST_WAIT) begin
        // wait for the line to read high
        if (in_data.line_in) begin
          phase_next      = PH_RST_REL2;
          tick_count_next = '0;
        end
      end else if (phase != PH_IDLE) begin
        tick_count_next = tick_inc;
        if (tick_inc >= len_cur) begin
          tick_count_next = '0;
          unique case (phase)
            PH_RST_LOW:  phase_next = PH_RST_REL1;
            PH_RST_REL1: phase_next = PH_RST_WAIT;
            PH_RST_REL2: fin = 1'b1;
            PH_SEND_LOW: phase_next = PH_SEND_REL;
            PH_SEND_REL: begin
              shift_byte_next = {1'b0, shift_byte[7:1]};
              bit_index_next  = bit_index + 3'd1;
              if (bit_index == 3'd7) fin = 1'b1;
              else phase_next = PH_SEND_LOW;
            end
            PH_RECV_LOW: phase_next = PH_RECV_REL;
            PH_RECV_REL: begin
              // sample the line into the top bit
              shift_byte_next = {in_data.line_in, shift_byte[7:1]};
              phase_next      = PH_RECV_TAIL;
            end
            PH_RECV_TAIL: begin
              bit_index_next = bit_index + 3'd1;
              if (bit_index == 3'd7) begin
                received_byte_next = shift_byte;
                fin                = 1'b1;
              end else begin
                phase_next = PH_RECV_LOW;
              end
            end
            PH_KEY_LOW: phase_next = PH_KEY_GAP;
            PH_KEY_GAP: begin
              shift_byte_next = {1'b0, shift_byte[7:1]};
              bit_index_next  = bit_index + 3'd1;
              if (bit_index == 3'd7) fin = 1'b1;
              else phase_next = PH_KEY_LOW;
            end
            default: phase_next = PH_IDLE;
          endcase
          if (fin) phase_next = PH_IDLE;
        end
      end
    end else if (phase == PH_IDLE) begin
      // start a command; unused codes fall through and change nothing
      unique case (in_data.op) inside
        OP_RESET, OP_SEND, OP_RECV, OP_KEY: begin
          tick_count_next = '0;
          bit_index_next  = '0;
          shift_byte_next = (in_data.op == OP_RECV) ? 8'd0 : in_data.data;
          unique case (in_data.op)
            OP_RESET: phase_next = PH_RST_LOW;
            OP_SEND:  phase_next = PH_SEND_LOW;
            OP_RECV:  phase_next = PH_RECV_LOW;
            default:  phase_next = PH_KEY_LOW;
          endcase
        end
        default: ;
      endcase
    end

    res.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_SEND_LOW) ||
                    (phase_next == PH_RECV_LOW) || (phase_next == PH_KEY_LOW);
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = fin;
    res.read_data = received_byte_next;
  end

  // advance the sequencer on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      received_byte <= '0;
    end else if (in_acc) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      received_byte <= received_byte_next;
    end
  end

  // hold results in the two-entry buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, in_acc} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop && (count == 2'd2)) begin
      slot0 <= slot1;
    end
    if (in_acc) begin
      if ((count == 2'd0) || ((count == 2'd1) && out_pop)) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end
  end

  `OWM_ASSERT_NOW(a_done_not_busy, !(out_valid && out_data.done_res && out_data.busy_res))
  `OWM_ASSERT_NOW(a_drive_needs_busy, !(out_valid && out_data.drive_low) || out_data.busy_res)
  `OWM_ASSERT_NOW(a_idle_count_clear, (phase != PH_IDLE) || (tick_count == '0))
  `OWM_ASSERT_NEXT(a_full_holds, (count == 2'd2) && out_stall, count == 2'd2)
  `OWM_ASSERT_NOW(a_count_range, count != 2'd3)

endmodule

`default_nettype wire

FILE: verif/one_wire_master_slot_timer_tb.sv
`timescale 1ns / 1ps

module one_wire_master_slot_timer_tb;
  import owm_pkg::*;

  localparam int     CLK_HALF      = 6;
  localparam int     RESET_CYCLES  = 6;
  localparam int     SETTLE_CYCLES = 4;
  localparam int     DRAIN_CYCLES  = 8;
  localparam longint CYCLE_LIMIT   = 200_000;

  // Op codes the block ignores
  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  typedef struct packed {
    owm_in_t    beat;
    logic [7:0] rep;
    logic       typed;
    owm_out_t   want;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  owm_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  owm_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Sequencer copy used for prediction
  phase_t              bus_phase;
  logic [2:0]          bus_op;
  logic [TICK_W-1:0]   tick_count;
  logic [2:0]          bit_pos;
  logic [7:0]          shift_reg;
  logic [7:0]          rx_byte;
  logic [TICK_W-1:0]   len_reg [7];

  owm_out_t    status_q [$];
  dir_row_t    dir_tab [$];
  owm_out_t    status_head;
  int unsigned mismatches  = 0;
  int          worked_beats = 0;
  longint      cycle_count = 0;
  int          calm_left   = 0;

  one_wire_master_slot_timer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Length of the current phase; a zero register acts as one
  function automatic logic [TICK_W-1:0] phase_ticks(phase_t p);
    logic one;
    one = shift_reg[0];
    case (p) inside
      PH_RST_LOW:               return len_reg[CFG_RESET_LOW];
      PH_RST_REL1, PH_RST_REL2: return len_reg[CFG_RESET_RELEASE];
      PH_SEND_LOW:  return one ? len_reg[CFG_SLOT_SHORT] : len_reg[CFG_SLOT_LONG];
      PH_SEND_REL:  return one ? len_reg[CFG_SLOT_LONG] : len_reg[CFG_SLOT_SHORT];
      PH_RECV_LOW, PH_RECV_REL: return len_reg[CFG_SLOT_SHORT];
      PH_RECV_TAIL: return len_reg[CFG_READ_TAIL];
      PH_KEY_LOW:   return one ? len_reg[CFG_KEY_PULSE] : 14'd1;
      PH_KEY_GAP:   return len_reg[CFG_KEY_GAP];
      default:      return 14'd1;
    endcase
  endfunction

  // Advance the sequencer copy by one beat and form its status
  task automatic step_master(input owm_in_t b, output owm_out_t r, output bit worked);
    bit fin;
    bit last;
    fin    = 1'b0;
    worked = 1'b0;
    if (b.op == OP_TICK) begin
      worked = (bus_phase != PH_IDLE);
      if (bus_phase == PH_RST_WAIT) begin
        // first high tick ends the wait
        if (b.line_in) begin
          bus_phase  = PH_RST_REL2;
          tick_count = '0;
        end
      end else if (bus_phase != PH_IDLE) begin
        tick_count = tick_count + 1'b1;
        if (tick_count >= phase_ticks(bus_phase)) begin
          tick_count = '0;
          last = (bit_pos == 3'd7);
          case (bus_phase) inside
            PH_RST_LOW:  bus_phase = PH_RST_REL1;
            PH_RST_REL1: bus_phase = PH_RST_WAIT;
            PH_RST_REL2: fin = 1'b1;
            PH_SEND_LOW: bus_phase = PH_SEND_REL;
            PH_KEY_LOW:  bus_phase = PH_KEY_GAP;
            PH_RECV_LOW: bus_phase = PH_RECV_REL;
            PH_SEND_REL, PH_KEY_GAP: begin
              shift_reg = shift_reg >> 1;
              bit_pos   = bit_pos + 1'b1;
              if (last) fin = 1'b1;
              else bus_phase = (bus_phase == PH_SEND_REL) ? PH_SEND_LOW : PH_KEY_LOW;
            end
            PH_RECV_REL: begin
              // sample on the last release tick, LSB first
              shift_reg = {b.line_in, shift_reg[7:1]};
              bus_phase = PH_RECV_TAIL;
            end
            PH_RECV_TAIL: begin
              bit_pos = bit_pos + 1'b1;
              if (last) begin
                rx_byte = shift_reg;
                fin     = 1'b1;
              end else begin
                bus_phase = PH_RECV_LOW;
              end
            end
            default: bus_phase = PH_IDLE;
          endcase
          if (fin) begin
            bus_phase = PH_IDLE;
            bus_op    = OP_TICK;
          end
        end
      end
    end else if (b.op <= OP_KEY && bus_phase == PH_IDLE) begin
      // load a start command; commands while busy fall through untouched
      worked     = 1'b1;
      bus_op     = b.op;
      tick_count = '0;
      bit_pos    = '0;
      shift_reg  = (b.op == OP_RECV) ? 8'h00 : b.data;
      case (b.op)
        OP_RESET: bus_phase = PH_RST_LOW;
        OP_SEND:  bus_phase = PH_SEND_LOW;
        OP_RECV:  bus_phase = PH_RECV_LOW;
        default:  bus_phase = PH_KEY_LOW;
      endcase
    end
    r.drive_low = (bus_phase == PH_RST_LOW) || (bus_phase == PH_SEND_LOW) ||
                  (bus_phase == PH_RECV_LOW) || (bus_phase == PH_KEY_LOW);
    r.busy_res  = (bus_phase != PH_IDLE);
    r.done_res  = fin;
    r.read_data = rx_byte;
  endtask

  // Mostly short gaps, a few long ones, with calm stretches of none
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Send one input beat, then log its status
  task automatic drive_item(input owm_in_t b, input bit typed, input owm_out_t want);
    int       gap;
    owm_out_t pred;
    bit       worked;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_master(b, pred, worked);
    if (worked) worked_beats++;
    status_q.push_back(typed ? want : pred);
  endtask

  // Write all timing registers once the block has drained
  task automatic configure(input int rlow, rrel, sshort, slong, tail, kpulse, kgap);
    logic [CFG_DATA_W-1:0] v [7];
    v[0] = CFG_DATA_W'(rlow);
    v[1] = CFG_DATA_W'(rrel);
    v[2] = CFG_DATA_W'(sshort);
    v[3] = CFG_DATA_W'(slong);
    v[4] = CFG_DATA_W'(tail);
    v[5] = CFG_DATA_W'(kpulse);
    v[6] = CFG_DATA_W'(kgap);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= v[i];
      @(posedge clk);
      case (i)
        CFG_RESET_LOW: len_reg[i] = {4'b0, v[i][9:0]};
        CFG_KEY_GAP:   len_reg[i] = v[i];
        default:       len_reg[i] = {6'b0, v[i][7:0]};
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Tick until the running operation ends, with a few stray commands
  task automatic finish_op();
    owm_in_t b;
    while (bus_phase != PH_IDLE) begin
      b.data = 8'($urandom);
      if ($urandom_range(0, 99) < 6) b.op = 3'($urandom_range(1, 7));
      else b.op = OP_TICK;
      if (bus_phase == PH_RST_WAIT) b.line_in = ($urandom_range(0, 9) < 3);
      else b.line_in = 1'($urandom);
      drive_item(b, 1'b0, '0);
    end
  endtask

  // Mostly clean operations, some raw beats of any op
  task automatic random_phase(input int budget);
    owm_in_t b;
    int      start;
    start = worked_beats;
    while (worked_beats - start < budget) begin
      if ($urandom_range(0, 99) < 85) b.op = 3'($urandom_range(1, 4));
      else b.op = 3'($urandom_range(0, 7));
      b.data    = 8'($urandom);
      b.line_in = 1'($urandom);
      drive_item(b, 1'b0, '0);
      finish_op();
    end
  endtask

  function automatic dir_row_t dir_row(logic [2:0] op, logic [7:0] data, logic line,
                                       int rep, logic typed, logic [10:0] want);
    dir_row_t r;
    r.beat.op      = op;
    r.beat.data    = data;
    r.beat.line_in = line;
    r.rep          = 8'(rep);
    r.typed        = typed;
    r.want         = want;
    return r;
  endfunction

  // Check each result beat against the oldest status
  task automatic check_field(input string name, input logic [7:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        status_head = status_q.pop_front();
        check_field("drive_low", status_head.drive_low, out_data.drive_low);
        check_field("busy_res", status_head.busy_res, out_data.busy_res);
        check_field("done_res", status_head.done_res, out_data.done_res);
        check_field("read_data", status_head.read_data, out_data.read_data);
      end
    end
  end

  // Stall the result side in bursts
  initial begin
    int run;
    int hold;
    while (rst) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 6);
      out_stall <= 1'b0;
      repeat (run + 1) @(posedge clk);
      hold = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    bus_phase  = PH_IDLE;
    bus_op     = OP_TICK;
    tick_count = '0;
    bit_pos    = '0;
    shift_reg  = '0;
    rx_byte    = '0;
    len_reg[CFG_RESET_LOW]     = {4'b0, RESET_LOW_DEF};
    len_reg[CFG_RESET_RELEASE] = {6'b0, RESET_RELEASE_DEF};
    len_reg[CFG_SLOT_SHORT]    = {6'b0, SLOT_SHORT_DEF};
    len_reg[CFG_SLOT_LONG]     = {6'b0, SLOT_LONG_DEF};
    len_reg[CFG_READ_TAIL]     = {6'b0, READ_TAIL_DEF};
    len_reg[CFG_KEY_PULSE]     = {6'b0, KEY_PULSE_DEF};
    len_reg[CFG_KEY_GAP]       = KEY_GAP_DEF;

    // Directed rows: idle and ignored beats, then each operation at unit lengths
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b0, 1, 1'b1, {1'b0, 1'b0, 1'b0, 8'h00}));
    dir_tab.push_back(dir_row(OP_UNUSED_LO,  8'hFF, 1'b1, 1, 1'b1, {1'b0, 1'b0, 1'b0, 8'h00}));
    dir_tab.push_back(dir_row(OP_UNUSED_MID, 8'h55, 1'b0, 1, 1'b1, {1'b0, 1'b0, 1'b0, 8'h00}));
    dir_tab.push_back(dir_row(OP_UNUSED_HI,  8'hAA, 1'b1, 1, 1'b1, {1'b0, 1'b0, 1'b0, 8'h00}));
    dir_tab.push_back(dir_row(OP_RESET,      8'h00, 1'b0, 1, 1'b1, {1'b1, 1'b1, 1'b0, 8'h00}));
    dir_tab.push_back(dir_row(OP_SEND,       8'hFF, 1'b1, 1, 1'b1, {1'b1, 1'b1, 1'b0, 8'h00}));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b0, 1, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b1, 1, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b0, 3, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b1, 1, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b0, 1, 1'b1, {1'b0, 1'b0, 1'b1, 8'h00}));
    dir_tab.push_back(dir_row(OP_SEND,       8'h00, 1'b0, 1, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b0, 16, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_SEND,       8'hFF, 1'b0, 1, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b1, 16, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_RECV,       8'h00, 1'b0, 1, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b1, 23, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b1, 1, 1'b1, {1'b0, 1'b0, 1'b1, 8'hFF}));
    dir_tab.push_back(dir_row(OP_RECV,       8'hFF, 1'b1, 1, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b0, 23, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b0, 1, 1'b1, {1'b0, 1'b0, 1'b1, 8'h00}));
    dir_tab.push_back(dir_row(OP_KEY,        8'h00, 1'b0, 1, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b0, 16, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_KEY,        8'hFF, 1'b1, 1, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_UNUSED_HI,  8'hFF, 1'b1, 1, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'h00, 1'b1, 16, 1'b0, '0));
    dir_tab.push_back(dir_row(OP_TICK,       8'hFF, 1'b1, 1, 1'b1, {1'b0, 1'b0, 1'b0, 8'h00}));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Zero lengths behave as one
    configure(0, 0, 0, 0, 0, 0, 0);
    foreach (dir_tab[i]) begin
      repeat (dir_tab[i].rep) drive_item(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
    end

    // Short random timings
    configure($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 4),
              $urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 5),
              $urandom_range(1, 6));
    random_phase(180);

    // Shortest legal timings
    configure(1, 1, 1, 1, 1, 1, 1);
    random_phase(100);

    // Mid-range random timings
    configure($urandom_range(1, 40), $urandom_range(1, 16), $urandom_range(1, 16),
              $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
              $urandom_range(1, 24));
    random_phase(60);

    // Drain and report
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
